FILE: design/rau_pkg.sv
package rau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned DivCntBits = $clog2(WordBits + 1);
  localparam logic [3:0] MaxExponent = 4'd15;

  typedef enum logic [3:0] {
    KindAdd  = 4'd0,
    KindSub  = 4'd1,
    KindMul  = 4'd2,
    KindDiv  = 4'd3,
    KindRed  = 4'd4,
    KindCmp  = 4'd5,
    KindPow  = 4'd6,
    KindInc  = 4'd7,
    KindDec  = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    OrdLess    = 2'd0,
    OrdEqual   = 2'd1,
    OrdGreater = 2'd2,
    OrdUnord   = 2'd3
  } order_e;

  typedef enum logic [1:0] {
    ErrOk     = 2'd0,
    ErrOpDen  = 2'd1,
    ErrResDen = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    SignZero = 2'd0,
    SignPos  = 2'd1,
    SignNeg  = 2'd2
  } sign_e;

  typedef enum logic [3:0] {
    StIdle,
    StGcdStart,
    StGcdDiv,
    StRedNum,
    StRedDen,
    StMul0,
    StMul1,
    StMul2,
    StMul3,
    StPow,
    StFinish,
    StOut
  } state_e;

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [31:0]  a_num;
    logic signed [31:0]  a_den;
    logic signed [31:0]  b_num;
    logic signed [31:0]  b_den;
    logic [3:0]          exponent;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         order;
    logic [1:0]         error_code;
    logic               a_is_zero;
    logic [1:0]         a_sign;
    logic               a_irreducible;
  } out_t;

endpackage

FILE: design/rational_arithmetic_unit.sv
// Rational fraction ALU. One item is taken while in_ready_o is high and its
// single result is held on out_data_o until taken; no new item is accepted
// before that. Every item runs a Euclid gcd on a (needed for the irreducible
// flag) on a restoring divider that retires one quotient bit a cycle, each
// remainder step ending with a test for the end; reduce adds two more
// divisions. Products use one 32x32 multiplier, one product a cycle, and power
// takes up to 15 multiplier passes, each on numerator and denominator. The
// quickest item has a zero denominator of a; the gcd on the divider sets the
// longest.
module rational_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::out_t  out_data_o
);

  rau_pkg::state_e state_q, state_d;
  rau_pkg::in_t    item_q;
  rau_pkg::out_t   res_q, res_d;

  // Euclid operands and the shared serial divider.
  logic [31:0] gx_q, gx_d, gy_q, gy_d;
  logic [31:0] dvd_q, dvd_d;       // dividend magnitude shifting out
  logic [31:0] dvs_q, dvs_d;       // divisor magnitude
  logic [31:0] rem_q, rem_d;       // partial remainder
  logic [31:0] quo_q, quo_d;
  logic [rau_pkg::DivCntBits-1:0] cnt_q, cnt_d;
  logic        nq_q, nq_d, nr_q, nr_d;
  logic [3:0]  pow_q, pow_d;
  logic [31:0] acc0_q, acc0_d, acc1_q, acc1_d;
  logic [63:0] p0_q, p0_d;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  logic [32:0] trial;
  assign trial = {rem_q, dvd_q[31]} - {1'b0, dvs_q};

  logic [31:0] an, ad, bn, bd;
  assign an = item_q.a_num;
  assign ad = item_q.a_den;
  assign bn = item_q.b_num;
  assign bd = item_q.b_den;

  logic op_err;
  assign op_err = (ad == '0) ||
      ((item_q.kind == rau_pkg::KindAdd || item_q.kind == rau_pkg::KindSub ||
        item_q.kind == rau_pkg::KindMul || item_q.kind == rau_pkg::KindDiv ||
        item_q.kind == rau_pkg::KindCmp) && bd == '0);

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  logic [1:0] sa, sb;  // 0 zero, 1 pos, 2 neg
  assign sa = (an == '0) ? 2'd0 : ((an[31] == ad[31]) ? 2'd1 : 2'd2);
  assign sb = (bn == '0) ? 2'd0 : ((bn[31] == bd[31]) ? 2'd1 : 2'd2);

  assign in_ready_o  = (state_q == rau_pkg::StIdle);
  assign out_valid_o = (state_q == rau_pkg::StOut);
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    nq_q   <= nq_d;
    nr_q   <= nr_d;
    pow_q  <= pow_d;
    acc0_q <= acc0_d;
    acc1_q <= acc1_d;
    p0_q   <= p0_d;
    res_q  <= res_d;
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  logic [31:0] qs, rs;
  logic [3:0]  e_sat;
  logic signed [2:0] c;

  always_comb begin
    state_d = state_q;
    gx_d = gx_q; gy_d = gy_q; dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q;
    quo_d = quo_q; cnt_d = cnt_q; nq_d = nq_q; nr_d = nr_q; pow_d = pow_q;
    acc0_d = acc0_q; acc1_d = acc1_q; p0_d = p0_q; res_d = res_q;
    mul_a = '0;
    mul_b = '0;
    qs = nq_q ? (32'd0 - quo_q) : quo_q;
    rs = nr_q ? (32'd0 - rem_q) : rem_q;
    e_sat = (item_q.exponent > rau_pkg::MaxExponent) ? rau_pkg::MaxExponent
                                                     : item_q.exponent;
    c = '0;
    case (state_q)
      rau_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = rau_pkg::StGcdStart;
          gx_d = in_data_i.a_num;
          gy_d = in_data_i.a_den;
        end
      end
      rau_pkg::StGcdStart: begin
        if (gy_q == '0) begin
          // gcd is done and sits in gx_q.
          res_d = '0;
          res_d.a_is_zero = (an == '0);
          res_d.a_sign = (ad == '0) ? rau_pkg::SignZero : sa;
          res_d.a_irreducible = (gx_q == 32'd1);
          if (op_err) begin
            state_d = rau_pkg::StOut;
            res_d.error_code = rau_pkg::ErrOpDen;
            if (item_q.kind == rau_pkg::KindCmp) res_d.order = rau_pkg::OrdUnord;
            if (item_q.kind > rau_pkg::KindDec) begin
              res_d.error_code = rau_pkg::ErrOk;
              res_d.res_num = an;
              res_d.res_den = ad;
            end
          end else if (item_q.kind == rau_pkg::KindRed) begin
            state_d = rau_pkg::StRedNum;
            dvd_d = mag(an); dvs_d = mag(gx_q); rem_d = '0; quo_d = '0;
            cnt_d = '0; nq_d = an[31] ^ gx_q[31]; nr_d = an[31];
          end else if (item_q.kind == rau_pkg::KindPow) begin
            state_d = rau_pkg::StPow;
            acc0_d = 32'd1; acc1_d = 32'd1; pow_d = '0;
          end else begin
            state_d = rau_pkg::StMul0;
          end
        end else begin
          state_d = rau_pkg::StGcdDiv;
          dvd_d = mag(gx_q); dvs_d = mag(gy_q); rem_d = '0; quo_d = '0;
          cnt_d = '0; nq_d = gx_q[31] ^ gy_q[31]; nr_d = gx_q[31];
        end
      end
      rau_pkg::StGcdDiv, rau_pkg::StRedNum, rau_pkg::StRedDen: begin
        if (cnt_q == rau_pkg::DivCntBits'(rau_pkg::WordBits)) begin
          case (state_q)
            rau_pkg::StGcdDiv: begin
              gx_d = gy_q;
              gy_d = rs;
              state_d = rau_pkg::StGcdStart;
            end
            rau_pkg::StRedNum: begin
              res_d.res_num = qs;
              dvd_d = mag(ad); dvs_d = mag(gx_q); rem_d = '0; quo_d = '0;
              cnt_d = '0; nq_d = ad[31] ^ gx_q[31]; nr_d = ad[31];
              state_d = rau_pkg::StRedDen;
            end
            default: begin
              res_d.res_den = qs;
              res_d.error_code = (qs == '0) ? rau_pkg::ErrResDen : rau_pkg::ErrOk;
              state_d = rau_pkg::StOut;
            end
          endcase
        end else begin
          cnt_d = cnt_q + 1'b1;
          dvd_d = {dvd_q[30:0], 1'b0};
          if (!trial[32]) begin
            rem_d = trial[31:0];
            quo_d = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = {rem_q[30:0], dvd_q[31]};
            quo_d = {quo_q[30:0], 1'b0};
          end
        end
      end
      rau_pkg::StMul0: begin
        // Compare uses magnitudes at full width, the rest wraps.
        if (item_q.kind == rau_pkg::KindCmp) begin
          mul_a = mag(an); mul_b = mag(bd);
        end else if (item_q.kind == rau_pkg::KindMul) begin
          mul_a = an; mul_b = bn;
        end else begin
          mul_a = an; mul_b = bd;
        end
        p0_d = mul_p;
        state_d = rau_pkg::StMul1;
      end
      rau_pkg::StMul1: begin
        if (item_q.kind == rau_pkg::KindCmp) begin
          mul_a = mag(bn); mul_b = mag(ad);
        end else if (item_q.kind == rau_pkg::KindDiv) begin
          mul_a = ad; mul_b = bn;
        end else begin
          mul_a = bn; mul_b = ad;
        end
        acc0_d = p0_q[31:0];
        p0_d = mul_p;
        state_d = rau_pkg::StMul2;
      end
      rau_pkg::StMul2: begin
        mul_a = ad; mul_b = bd;
        acc1_d = mul_p[31:0];
        state_d = rau_pkg::StMul3;
        case (item_q.kind)
          rau_pkg::KindAdd: acc0_d = acc0_q + p0_q[31:0];
          rau_pkg::KindSub: acc0_d = acc0_q - p0_q[31:0];
          rau_pkg::KindDiv: acc1_d = p0_q[31:0];
          rau_pkg::KindInc: begin acc0_d = an + ad; acc1_d = ad; end
          rau_pkg::KindDec: begin acc0_d = an - ad; acc1_d = ad; end
          rau_pkg::KindCmp: begin
            // p0_q holds |bn*ad|; rebuild |an*bd| from the multiplier.
            mul_a = mag(an); mul_b = mag(bd);
            if (sa != sb) begin
              res_d.order = (sa == 2'd2 || (sa == 2'd0 && sb == 2'd1))
                  ? rau_pkg::OrdLess : rau_pkg::OrdGreater;
            end else if (sa == 2'd0) begin
              res_d.order = rau_pkg::OrdEqual;
            end else begin
              c = (mul_p < p0_q) ? -3'sd1 : ((mul_p == p0_q) ? 3'sd0 : 3'sd1);
              if (sa == 2'd2) c = -c;
              res_d.order = (c < 0) ? rau_pkg::OrdLess :
                  ((c == 0) ? rau_pkg::OrdEqual : rau_pkg::OrdGreater);
            end
            state_d = rau_pkg::StOut;
          end
          rau_pkg::KindMul: ;
          default: begin acc0_d = an; acc1_d = ad; end
        endcase
      end
      rau_pkg::StMul3: begin
        res_d.res_num = acc0_q;
        res_d.res_den = acc1_q;
        if (item_q.kind <= rau_pkg::KindDec && acc1_q == '0)
          res_d.error_code = rau_pkg::ErrResDen;
        state_d = rau_pkg::StOut;
      end
      rau_pkg::StPow: begin
        // One pass alternates numerator and denominator on the multiplier.
        if (pow_q[3:0] == e_sat && !cnt_q[0]) begin
          acc0_d = acc0_q;
          state_d = rau_pkg::StMul3;
        end else if (!cnt_q[0]) begin
          mul_a = acc0_q; mul_b = an;
          acc0_d = mul_p[31:0];
          cnt_d = {{(rau_pkg::DivCntBits-1){1'b0}}, 1'b1};
        end else begin
          mul_a = acc1_q; mul_b = ad;
          acc1_d = mul_p[31:0];
          cnt_d = '0;
          pow_d = pow_q + 1'b1;
        end
      end
      rau_pkg::StFinish: begin
        state_d = rau_pkg::StOut;
      end
      rau_pkg::StOut: begin
        if (out_ready_i) state_d = rau_pkg::StIdle;
      end
      default: state_d = rau_pkg::StIdle;
    endcase
    if (state_q == rau_pkg::StGcdStart && gy_q == '0 &&
        item_q.kind == rau_pkg::KindPow && !op_err) begin
      cnt_d = '0;
    end
  end

endmodule

FILE: design/rau_checker.sv
module rau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rau_pkg::out_t out_data_o
);

  // The unit never offers a result and takes an item at once.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
      else $error("result dropped");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (out_data_o.error_code != 2'd3 && out_data_o.a_sign != 2'd3))
      else $error("bad code");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
